// ----- sv/dtq_pkg.sv -----
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int AMT_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [1:0]          cell_sel_t;
    typedef logic [1:0]          chain_op_t;

    // input kinds
    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_ADD  = 2'd1;
    localparam kind_t KIND_DEL  = 2'd2;

    // result status codes
    localparam status_t STATUS_EXPIRED  = 3'd0;
    localparam status_t STATUS_ADDED    = 3'd1;
    localparam status_t STATUS_FULL     = 3'd2;
    localparam status_t STATUS_REMOVED  = 3'd3;
    localparam status_t STATUS_NOTFOUND = 3'd4;

    // per-cell source select
    localparam cell_sel_t SEL_HOLD  = 2'd0;
    localparam cell_sel_t SEL_LEFT  = 2'd1;
    localparam cell_sel_t SEL_RIGHT = 2'd2;
    localparam cell_sel_t SEL_LOAD  = 2'd3;

    // chain-wide operation
    localparam chain_op_t OP_NONE  = 2'd0;
    localparam chain_op_t OP_SHL   = 2'd1;
    localparam chain_op_t OP_INS   = 2'd2;
    localparam chain_op_t OP_LOAD  = 2'd3;

endpackage

// ----- sv/dtq_cell.sv -----
`timescale 1ns / 1ps

module dtq_cell #(
    parameter int TASK_ID_BITS = 8
) (
    input  logic                      clk,
    input  dtq_pkg::cell_sel_t        sel,
    input  logic [TASK_ID_BITS-1:0]   left_task,
    input  logic [dtq_pkg::AMT_W-1:0] left_delta,
    input  logic [TASK_ID_BITS-1:0]   right_task,
    input  logic [dtq_pkg::AMT_W-1:0] right_delta,
    input  logic [TASK_ID_BITS-1:0]   load_task,
    input  logic [dtq_pkg::AMT_W-1:0] load_delta,
    output logic [TASK_ID_BITS-1:0]   task_out,
    output logic [dtq_pkg::AMT_W-1:0] delta_out
);

    logic [TASK_ID_BITS-1:0]   task_reg;
    logic [TASK_ID_BITS-1:0]   task_next;
    logic [dtq_pkg::AMT_W-1:0] delta_reg;
    logic [dtq_pkg::AMT_W-1:0] delta_next;

    always_comb
    begin
        unique case (sel)
            dtq_pkg::SEL_LEFT:
            begin
                task_next  = left_task;
                delta_next = left_delta;
            end
            dtq_pkg::SEL_RIGHT:
            begin
                task_next  = right_task;
                delta_next = right_delta;
            end
            dtq_pkg::SEL_LOAD:
            begin
                task_next  = load_task;
                delta_next = load_delta;
            end
            default:
            begin
                task_next  = task_reg;
                delta_next = delta_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        task_reg  <= task_next;
        delta_reg <= delta_next;
    end

    assign task_out  = task_reg;
    assign delta_out = delta_reg;

endmodule

// ----- sv/delta_timeout_queue.sv -----
`timescale 1ns / 1ps

// channel  dir  tvalid/tready handshake   payload
// -------  ---  ------------------------  ---------------------------------------
// s_       in   s_tvalid / s_tready       tuser: kind; tdata: task_id, amount
// m_       out  m_tvalid / m_tready       tuser: status; tdata: task_id_out; tlast
//
// one transaction is taken at a time; s_tready is high only while idle
// tick: expires entries off the head in turn, then takes the rest off the new head;
// add: reports full, or walks past entries the amount covers and inserts; delete:
// compares entries in turn, reports an absent task, and folds the removed delta
// into the successor; each result sits in an output register; a stalled m_tready
// holds the walk; rst_n clears the entry count, the state and the output valid; cell
// payload is not reset and is only read below the entry count

module delta_timeout_queue #(
    parameter int DEPTH        = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // task_id, amount
    input  logic [((TASK_ID_BITS+39)/8)*8-1:0]    s_tdata,
    // kind
    input  logic [dtq_pkg::KIND_W-1:0]            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // task_id_out
    output logic [((TASK_ID_BITS+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [dtq_pkg::STATUS_W-1:0]          m_tuser,
    output logic                                  m_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX1  = (DEPTH > 1) ? 1 : 0;
    localparam int OUT_W = ((TASK_ID_BITS + 7) / 8) * 8;
    localparam int AW    = dtq_pkg::AMT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]           amt_reg, amt_next;
    logic [TASK_ID_BITS-1:0] id_reg, id_next;
    logic [AW-1:0]           fold_reg, fold_next;

    logic                    out_valid_reg, out_valid_next;
    dtq_pkg::status_t        out_status_reg, out_status_next;
    logic [TASK_ID_BITS-1:0] out_task_reg, out_task_next;
    logic                    out_last_reg, out_last_next;

    // chain view
    logic [TASK_ID_BITS-1:0] task_q  [DEPTH];
    logic [AW-1:0]           delta_q [DEPTH];
    logic [TASK_ID_BITS-1:0] cur_task;
    logic [AW-1:0]           cur_delta;
    logic [AW-1:0]           cur_sub;
    logic [AW-1:0]           cur_fold;
    logic [CNT_W-1:0]        ptr_inc;

    dtq_pkg::chain_op_t      op;
    logic [AW-1:0]           ld_delta;

    logic                    step_ok;
    logic                    head_exp;
    logic                    next_exp;
    logic                    add_stop;
    logic [AW:0]             head_pair;

    // result about to be pushed into the output register
    logic                    emit;
    dtq_pkg::status_t        e_status;
    logic [TASK_ID_BITS-1:0] e_task;
    logic                    e_last;

    assign cur_task  = task_q[ptr_reg[IDX_W-1:0]];
    assign cur_delta = delta_q[ptr_reg[IDX_W-1:0]];
    assign cur_sub   = cur_delta - amt_reg;
    assign cur_fold  = cur_delta + fold_reg;
    assign ptr_inc   = ptr_reg + CNT_W'(1);

    // head reached and whether the second entry is reached as well
    assign head_exp  = (count_reg != '0) && (delta_q[0] <= amt_reg);
    assign head_pair = {1'b0, delta_q[0]} + {1'b0, delta_q[IDX1]};
    assign next_exp  = (count_reg > CNT_W'(1)) && (head_pair <= {1'b0, amt_reg});
    assign add_stop  = (ptr_reg == count_reg) || (amt_reg < cur_delta);

    assign step_ok   = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        amt_next   = amt_reg;
        id_next    = id_reg;
        fold_next  = fold_reg;
        op         = dtq_pkg::OP_NONE;
        ld_delta   = cur_sub;
        emit       = 1'b0;
        e_status   = dtq_pkg::STATUS_EXPIRED;
        e_task     = id_reg;
        e_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ptr_next = '0;
                    id_next  = s_tdata[TASK_ID_BITS-1:0];
                    amt_next = s_tdata[TASK_ID_BITS +: AW];
                    unique case (s_tuser)
                        dtq_pkg::KIND_TICK: state_next = S_TICK;
                        dtq_pkg::KIND_ADD:  state_next = S_ADD;
                        dtq_pkg::KIND_DEL:  state_next = S_DEL;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_TICK:
            begin
                if (step_ok)
                begin
                    if (head_exp)
                    begin
                        // drop the head, successor delta stays relative
                        emit       = 1'b1;
                        e_status   = dtq_pkg::STATUS_EXPIRED;
                        e_task     = task_q[0];
                        e_last     = !next_exp;
                        op         = dtq_pkg::OP_SHL;
                        count_next = count_reg - CNT_W'(1);
                        amt_next   = amt_reg - delta_q[0];
                    end
                    else
                    begin
                        // remaining time comes off the new head
                        if (count_reg != '0)
                        begin
                            op       = dtq_pkg::OP_LOAD;
                            ld_delta = cur_sub;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_ADD:
            begin
                if (step_ok)
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        emit       = 1'b1;
                        e_status   = dtq_pkg::STATUS_FULL;
                        state_next = S_IDLE;
                    end
                    else if (add_stop)
                    begin
                        op         = dtq_pkg::OP_INS;
                        count_next = count_reg + CNT_W'(1);
                        emit       = 1'b1;
                        e_status   = dtq_pkg::STATUS_ADDED;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        amt_next = amt_reg - cur_delta;
                        ptr_next = ptr_inc;
                    end
                end
            end
            S_DEL:
            begin
                if (step_ok)
                begin
                    if (ptr_reg == count_reg)
                    begin
                        emit       = 1'b1;
                        e_status   = dtq_pkg::STATUS_NOTFOUND;
                        state_next = S_IDLE;
                    end
                    else if (cur_task == id_reg)
                    begin
                        op         = dtq_pkg::OP_SHL;
                        count_next = count_reg - CNT_W'(1);
                        fold_next  = cur_delta;
                        if (ptr_inc < count_reg)
                        begin
                            state_next = S_FOLD;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            e_status   = dtq_pkg::STATUS_REMOVED;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                    end
                end
            end
            S_FOLD:
            begin
                if (step_ok)
                begin
                    // successor now sits at the removed slot
                    op         = dtq_pkg::OP_LOAD;
                    ld_delta   = cur_fold;
                    emit       = 1'b1;
                    e_status   = dtq_pkg::STATUS_REMOVED;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = e_status;
            out_task_next   = e_task;
            out_last_next   = e_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // chain of cells: each cell picks hold, left, right or a load value
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            dtq_pkg::cell_sel_t      sel;
            logic [TASK_ID_BITS-1:0] left_task;
            logic [AW-1:0]           left_delta;
            logic [TASK_ID_BITS-1:0] right_task;
            logic [AW-1:0]           right_delta;
            logic [TASK_ID_BITS-1:0] load_task;
            logic [AW-1:0]           load_delta;

            if (k == 0)
            begin : g_first
                assign left_task  = '0;
                assign left_delta = '0;
            end
            else
            begin : g_mid_l
                assign left_task  = task_q[k-1];
                assign left_delta = delta_q[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign right_task  = '0;
                assign right_delta = '0;
            end
            else
            begin : g_mid_r
                assign right_task  = task_q[k+1];
                assign right_delta = delta_q[k+1];
            end

            always_comb
            begin
                sel        = dtq_pkg::SEL_HOLD;
                load_task  = cur_task;
                load_delta = ld_delta;
                unique case (op)
                    dtq_pkg::OP_SHL:
                    begin
                        if (CNT_W'(k) >= ptr_reg)
                        begin
                            sel = dtq_pkg::SEL_RIGHT;
                        end
                    end
                    dtq_pkg::OP_INS:
                    begin
                        if (CNT_W'(k) == ptr_reg)
                        begin
                            sel        = dtq_pkg::SEL_LOAD;
                            load_task  = id_reg;
                            load_delta = amt_reg;
                        end
                        else if (CNT_W'(k) == ptr_inc)
                        begin
                            // old entry moves up with the new task's share taken off
                            sel        = dtq_pkg::SEL_LOAD;
                            load_task  = left_task;
                            load_delta = cur_sub;
                        end
                        else if (CNT_W'(k) > ptr_inc)
                        begin
                            sel = dtq_pkg::SEL_LEFT;
                        end
                    end
                    dtq_pkg::OP_LOAD:
                    begin
                        if (CNT_W'(k) == ptr_reg)
                        begin
                            sel = dtq_pkg::SEL_LOAD;
                        end
                    end
                    default:
                    begin
                        sel = dtq_pkg::SEL_HOLD;
                    end
                endcase
            end

            dtq_cell #(
                .TASK_ID_BITS (TASK_ID_BITS)
            ) u_cell (
                .clk         (clk),
                .sel         (sel),
                .left_task   (left_task),
                .left_delta  (left_delta),
                .right_task  (right_task),
                .right_delta (right_delta),
                .load_task   (load_task),
                .load_delta  (load_delta),
                .task_out    (task_q[k]),
                .delta_out   (delta_q[k])
            );
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        amt_reg        <= amt_next;
        id_reg         <= id_next;
        fold_reg       <= fold_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_W'(out_task_reg);
    assign m_tlast  = out_last_reg;

    // entry count never passes the chain length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // the walk pointer never runs past the valid entries
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (ptr_reg <= count_reg))
        else $error("walk pointer beyond entry count");

    // a successful insert grows the queue by one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (e_status == dtq_pkg::STATUS_ADDED))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    // every expiry shrinks the queue by one
    a_expire_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (state_reg == S_TICK))
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("expiry did not shrink the queue");

    // results are only produced when the output register can take them
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> step_ok)
        else $error("result produced while output register is blocked");

endmodule
